/* design/dmph_pkg.sv */
// Shared types and constants for the dot matrix print head.
// Used by every module of the block; depends on nothing.
package dmph_pkg;

  localparam int FONT_CHARS    = 96;
  localparam int COLS_PER_CHAR = 5;
  localparam int COORD_BITS    = 12;

  localparam int STORE_SIZE  = FONT_CHARS * COLS_PER_CHAR;
  localparam int ADDR_W      = $clog2(STORE_SIZE);
  localparam int PRINT_CHARS = 96;
  localparam int BASE_W      = $clog2(PRINT_CHARS * COLS_PER_CHAR + 1);
  localparam int COL_W       = $clog2(COLS_PER_CHAR + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 12;

  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] CHAR_LF     = 8'd10;
  localparam logic [7:0] CHAR_FIRST  = 8'd32;
  localparam logic [7:0] CHAR_LAST   = 8'd127;
  localparam logic [7:0] DOTS_SOLID  = 8'd255;
  localparam logic [3:0] FEED_GRAPH  = 4'd8;
  localparam logic [3:0] FEED_TEXT   = 4'd10;
  localparam logic [3:0] HEAD_MARGIN = 4'd10;

  localparam logic [CFG_ADDR_W-1:0] CFG_PAGE_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PAGE_HEIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNDERLINE   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_GRAPHICS    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNIX        = 3'd4;

  localparam logic [COORD_BITS-1:0] PAGE_WIDTH_RST  = 12'd510;
  localparam logic [COORD_BITS-1:0] PAGE_HEIGHT_RST = 12'd660;

  localparam logic KIND_COLUMN = 1'b0;
  localparam logic KIND_PAGE   = 1'b1;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_CR,
    OP_LF,
    OP_TEXT,
    OP_SOLID
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_COL,
    B_PAGE
  } bstate_t;

  typedef struct packed {
    logic       command;
    logic [7:0] char_code;
    logic [8:0] font_index;
    logic [7:0] font_data;
  } in_t;

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] column_x;
    logic [COORD_BITS-1:0] row_y;
    logic [7:0]            dots;
    logic                  underline_dot;
    logic                  last;
  } out_t;

  typedef struct packed {
    op_t               op;
    logic [BASE_W-1:0] base;
    logic [ADDR_W-1:0] font_addr;
    logic [7:0]        font_data;
  } cmd_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] page_width;
    logic [COORD_BITS-1:0] page_height;
    logic                  underline_on;
    logic                  graphics_mode;
    logic                  unix_mode;
  } cfg_t;

endpackage

/* design/dmph_front.sv */
// Front stage: accepts input words, classifies them and holds one command.
// Depends on dmph_pkg.
module dmph_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  dmph_pkg::in_t   in_data,
  output logic            f_valid,
  output dmph_pkg::cmd_t  f_cmd,
  input  logic            q_full
);

  logic           f_valid_r, f_valid_nxt;
  dmph_pkg::cmd_t f_cmd_r, f_cmd_nxt;
  dmph_pkg::cmd_t cls;
  logic [6:0]     ofs;
  logic           accept, push;

  always_comb begin
    ofs            = in_data.char_code[6:0] - dmph_pkg::CHAR_FIRST[6:0];
    cls.op         = dmph_pkg::OP_NOP;
    cls.base       = dmph_pkg::BASE_W'(dmph_pkg::BASE_W'(ofs) *
                     dmph_pkg::BASE_W'(dmph_pkg::COLS_PER_CHAR));
    cls.font_addr  = dmph_pkg::ADDR_W'(in_data.font_index);
    cls.font_data  = in_data.font_data;
    if (in_data.command) begin
      if (in_data.font_index < dmph_pkg::STORE_SIZE) cls.op = dmph_pkg::OP_LOAD;
    end else if (in_data.char_code < dmph_pkg::CHAR_FIRST) begin
      if (in_data.char_code == dmph_pkg::CHAR_CR) cls.op = dmph_pkg::OP_CR;
      else if (in_data.char_code == dmph_pkg::CHAR_LF) cls.op = dmph_pkg::OP_LF;
    end else if (in_data.char_code > dmph_pkg::CHAR_LAST) begin
      cls.op = dmph_pkg::OP_SOLID;
    end else begin
      cls.op = dmph_pkg::OP_TEXT;
    end
  end

  assign push     = f_valid_r && !q_full;
  assign in_stall = f_valid_r && q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    f_valid_nxt = f_valid_r && !push;
    f_cmd_nxt   = f_cmd_r;
    if (accept) begin
      f_valid_nxt = (cls.op != dmph_pkg::OP_NOP);
      f_cmd_nxt   = cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
    f_cmd_r <= f_cmd_nxt;
  end

  assign f_valid = f_valid_r;
  assign f_cmd   = f_cmd_r;

endmodule

/* design/dmph_queue.sv */
// Command queue between front and back stages.
// Depends on dmph_pkg.
module dmph_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dmph_pkg::cmd_t push_cmd,
  output logic           q_full,
  input  logic           pop,
  output logic           q_valid,
  output dmph_pkg::cmd_t q_cmd
);

  dmph_pkg::cmd_t                  slot_r [dmph_pkg::QUEUE_DEPTH];
  logic [dmph_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [dmph_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [dmph_pkg::QCNT_W-1:0]     count_r, count_nxt;
  logic                            do_push, do_pop;

  assign q_full  = (count_r == dmph_pkg::QCNT_W'(dmph_pkg::QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = slot_r[rd_ptr_r];
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == dmph_pkg::QPTR_W'(dmph_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == dmph_pkg::QPTR_W'(dmph_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) slot_r[wr_ptr_r] <= push_cmd;
  end

endmodule

/* design/dmph_back.sv */
// Back stage: font store, head position, column sequencer and output register.
// Depends on dmph_pkg.
module dmph_back (
  input  logic           clk,
  input  logic           rst_n,
  input  dmph_pkg::cfg_t cfg,
  input  logic           q_valid,
  input  dmph_pkg::cmd_t q_cmd,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output dmph_pkg::out_t out_data
);

  logic [7:0] font_mem [dmph_pkg::STORE_SIZE];

  dmph_pkg::bstate_t                 state_r, state_nxt;
  logic [dmph_pkg::COORD_BITS-1:0]   x_r, x_nxt;
  logic [dmph_pkg::COORD_BITS-1:0]   y_r, y_nxt;
  logic [dmph_pkg::BASE_W-1:0]       base_r, base_nxt;
  logic [dmph_pkg::COL_W-1:0]        col_r, col_nxt;
  logic                              solid_r, solid_nxt;
  logic                              final_r, final_nxt;
  logic [7:0]                        rd_data_r;
  logic                              rd_ok_r;
  logic                              out_valid_r, out_valid_nxt;
  dmph_pkg::out_t                    out_r, out_nxt;

  logic                              emit_ok, mem_we, rd_go, rd_in;
  logic [dmph_pkg::BASE_W-1:0]       rd_a;
  logic [dmph_pkg::COORD_BITS:0]     nx, lf_y;
  logic [dmph_pkg::COORD_BITS+1:0]   lf_lim;
  logic                              wrap, lf_page, is_final, ul;
  logic [7:0]                        col_dots;
  dmph_pkg::out_t                    page_res, col_res;

  assign emit_ok  = !out_valid_r || !out_stall;
  assign nx       = {1'b0, x_r} + 1'b1;
  assign wrap     = nx > {1'b0, cfg.page_width};
  assign lf_y     = {1'b0, y_r} + (cfg.graphics_mode ? dmph_pkg::FEED_GRAPH :
                                                       dmph_pkg::FEED_TEXT);
  assign lf_lim   = {1'b0, lf_y} + dmph_pkg::HEAD_MARGIN;
  assign lf_page  = lf_lim > {2'b00, cfg.page_height};
  assign is_final = (col_r == dmph_pkg::COL_W'(dmph_pkg::COLS_PER_CHAR));
  assign ul       = cfg.underline_on && !cfg.graphics_mode;
  assign rd_in    = rd_a < dmph_pkg::STORE_SIZE;

  always_comb begin
    if (solid_r) col_dots = dmph_pkg::DOTS_SOLID;
    else if (!is_final && rd_ok_r) col_dots = rd_data_r;
    else col_dots = 8'd0;

    page_res.kind          = dmph_pkg::KIND_PAGE;
    page_res.column_x      = '0;
    page_res.row_y         = '0;
    page_res.dots          = 8'd0;
    page_res.underline_dot = 1'b0;
    page_res.last          = 1'b1;

    col_res.kind           = dmph_pkg::KIND_COLUMN;
    col_res.column_x       = x_r;
    col_res.row_y          = y_r;
    col_res.dots           = col_dots;
    col_res.underline_dot  = ul;
    col_res.last           = is_final && !(wrap && lf_page);
  end

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    base_nxt      = base_r;
    col_nxt       = col_r;
    solid_nxt     = solid_r;
    final_nxt     = final_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    rd_go         = 1'b0;
    rd_a          = base_r + dmph_pkg::BASE_W'(col_r) + 1'b1;
    case (state_r)
      dmph_pkg::B_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            dmph_pkg::OP_LOAD: begin
              mem_we = 1'b1;
              pop    = 1'b1;
            end
            dmph_pkg::OP_CR: begin
              x_nxt = '0;
              pop   = 1'b1;
            end
            dmph_pkg::OP_LF: begin
              if (lf_page) begin
                if (emit_ok) begin
                  out_valid_nxt = 1'b1;
                  out_nxt       = page_res;
                  x_nxt         = '0;
                  y_nxt         = '0;
                  pop           = 1'b1;
                end
              end else begin
                if (cfg.unix_mode) x_nxt = '0;
                y_nxt = lf_y[dmph_pkg::COORD_BITS-1:0];
                pop   = 1'b1;
              end
            end
            dmph_pkg::OP_TEXT, dmph_pkg::OP_SOLID: begin
              base_nxt  = q_cmd.base;
              solid_nxt = (q_cmd.op == dmph_pkg::OP_SOLID);
              col_nxt   = '0;
              rd_a      = q_cmd.base;
              rd_go     = (q_cmd.op == dmph_pkg::OP_TEXT);
              pop       = 1'b1;
              state_nxt = dmph_pkg::B_COL;
            end
            default: pop = 1'b1;
          endcase
        end
      end
      dmph_pkg::B_COL: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_nxt       = col_res;
          final_nxt     = is_final;
          if (wrap) begin
            x_nxt = '0;
            y_nxt = lf_page ? '0 : lf_y[dmph_pkg::COORD_BITS-1:0];
          end else begin
            x_nxt = nx[dmph_pkg::COORD_BITS-1:0];
          end
          if (wrap && lf_page) begin
            state_nxt = dmph_pkg::B_PAGE;
          end else if (is_final) begin
            state_nxt = dmph_pkg::B_IDLE;
          end else begin
            col_nxt = col_r + 1'b1;
            rd_go   = !solid_r;
          end
        end
      end
      dmph_pkg::B_PAGE: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_nxt       = page_res;
          out_nxt.last  = final_r;
          if (final_r) begin
            state_nxt = dmph_pkg::B_IDLE;
          end else begin
            col_nxt   = col_r + 1'b1;
            rd_go     = !solid_r;
            state_nxt = dmph_pkg::B_COL;
          end
        end
      end
      default: state_nxt = dmph_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) font_mem[q_cmd.font_addr] <= q_cmd.font_data;
    if (rd_go) begin
      rd_ok_r <= rd_in;
      if (rd_in) rd_data_r <= font_mem[dmph_pkg::ADDR_W'(rd_a)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dmph_pkg::B_IDLE;
      x_r         <= '0;
      y_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      out_valid_r <= out_valid_nxt;
    end
    base_r  <= base_nxt;
    col_r   <= col_nxt;
    solid_r <= solid_nxt;
    final_r <= final_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* design/dot_matrix_print_head.sv */
// Top level of the dot matrix print head: configuration registers and
// the front stage, command queue and back stage. Depends on dmph_pkg.
//
//   port group   dir  handshake          payload
//   in_          in   in_valid/in_stall  in_data   (dmph_pkg::in_t)
//   out_         out  out_valid/out_stall out_data (dmph_pkg::out_t)
//   cfg_         in   cfg_we             cfg_addr, cfg_wdata
//
// The back stage handles a font load, CR or LF as it dequeues it; for a
// printing character it dequeues the word and starts the font read, then
// fires its columns in turn, with a page-end word when the page fills.
// The back stage's single output register sets the column rate. The front
// holds one word and the queue four, so input flows on while out_stall
// holds the back stage until both fill. Reset clears the head position and
// queue and resets the config; the font store is not cleared.
module dot_matrix_print_head (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dmph_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dmph_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [dmph_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [dmph_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  dmph_pkg::cfg_t cfg_r, cfg_nxt;
  logic           f_valid, q_full, q_valid, pop;
  dmph_pkg::cmd_t f_cmd, q_cmd;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        dmph_pkg::CFG_PAGE_WIDTH:  cfg_nxt.page_width    = cfg_wdata;
        dmph_pkg::CFG_PAGE_HEIGHT: cfg_nxt.page_height   = cfg_wdata;
        dmph_pkg::CFG_UNDERLINE:   cfg_nxt.underline_on  = cfg_wdata[0];
        dmph_pkg::CFG_GRAPHICS:    cfg_nxt.graphics_mode = cfg_wdata[0];
        dmph_pkg::CFG_UNIX:        cfg_nxt.unix_mode     = cfg_wdata[0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.page_width    <= dmph_pkg::PAGE_WIDTH_RST;
      cfg_r.page_height   <= dmph_pkg::PAGE_HEIGHT_RST;
      cfg_r.underline_on  <= 1'b0;
      cfg_r.graphics_mode <= 1'b0;
      cfg_r.unix_mode     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dmph_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .f_valid  (f_valid),
    .f_cmd    (f_cmd),
    .q_full   (q_full)
  );

  dmph_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_valid),
    .push_cmd (f_cmd),
    .q_full   (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  dmph_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* bench/tb_dot_matrix_print_head.sv */
// Self-checking bench for dot_matrix_print_head: random and directed character
// streams, with an in-bench predictor of head motion and fired columns.
// Depends on dmph_pkg and the dot_matrix_print_head RTL.
module tb_dot_matrix_print_head;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_PRINT = 1'b0;
  localparam logic CMD_LOAD  = 1'b1;
  localparam logic [dmph_pkg::CFG_ADDR_W-1:0] CFG_SPARE = 3'd7;
  localparam logic [7:0] LOADED_LAST = 8'd47;
  localparam int LOADED_ENTRIES =
    (int'(LOADED_LAST) - int'(dmph_pkg::CHAR_FIRST) + 1) * dmph_pkg::COLS_PER_CHAR;
  localparam int LAST_CHAR_BASE =
    (int'(dmph_pkg::CHAR_LAST) - int'(dmph_pkg::CHAR_FIRST)) * dmph_pkg::COLS_PER_CHAR;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 32;
  localparam int PHASES = 6;
  localparam int PHASE_WORDS = 42;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  dmph_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  dmph_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [dmph_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [dmph_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  dot_matrix_print_head dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dmph_pkg::in_t char_stream[$];
  dmph_pkg::out_t column_forecast[$];
  int words_queued = 0;
  int words_taken = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  logic [dmph_pkg::COORD_BITS-1:0] pg_width = dmph_pkg::PAGE_WIDTH_RST;
  logic [dmph_pkg::COORD_BITS-1:0] pg_height = dmph_pkg::PAGE_HEIGHT_RST;
  logic ul_on = 1'b0;
  logic gfx_on = 1'b0;
  logic unix_on = 1'b0;
  logic [12:0] head_col = '0;
  logic [11:0] head_row = '0;
  logic [7:0] font_copy [dmph_pkg::STORE_SIZE];

  function automatic void feed_paper();
    int next_row;
    next_row = int'(head_row) + (gfx_on ? int'(dmph_pkg::FEED_GRAPH) :
                                          int'(dmph_pkg::FEED_TEXT));
    if (unix_on) head_col = '0;
    if (next_row + int'(dmph_pkg::HEAD_MARGIN) > int'(pg_height)) begin
      column_forecast.push_back('{kind: dmph_pkg::KIND_PAGE, column_x: '0, row_y: '0,
                                  dots: '0, underline_dot: 1'b0, last: 1'b0});
      head_col = '0;
      head_row = '0;
    end else begin
      head_row = next_row[11:0];
    end
  endfunction

  function automatic void strike_column(logic [7:0] pattern);
    column_forecast.push_back('{kind: dmph_pkg::KIND_COLUMN,
                                column_x: head_col[dmph_pkg::COORD_BITS-1:0],
                                row_y: head_row, dots: pattern,
                                underline_dot: ul_on && !gfx_on, last: 1'b0});
    head_col = head_col + 13'd1;
    if (head_col > {1'b0, pg_width}) begin
      feed_paper();
      head_col = '0;
    end
  endfunction

  function automatic void strike_char(dmph_pkg::in_t word);
    int base;
    int before_cnt;
    dmph_pkg::out_t tail;
    before_cnt = column_forecast.size();
    if (word.command == CMD_LOAD) begin
      if (int'(word.font_index) < dmph_pkg::STORE_SIZE)
        font_copy[word.font_index] = word.font_data;
    end else if (word.char_code < dmph_pkg::CHAR_FIRST) begin
      if (word.char_code == dmph_pkg::CHAR_CR) head_col = '0;
      else if (word.char_code == dmph_pkg::CHAR_LF) feed_paper();
    end else if (word.char_code > dmph_pkg::CHAR_LAST) begin
      for (int i = 0; i <= dmph_pkg::COLS_PER_CHAR; i++) strike_column(dmph_pkg::DOTS_SOLID);
    end else begin
      base = (int'(word.char_code) - int'(dmph_pkg::CHAR_FIRST)) * dmph_pkg::COLS_PER_CHAR;
      for (int i = 0; i < dmph_pkg::COLS_PER_CHAR; i++)
        strike_column(base + i < dmph_pkg::STORE_SIZE ? font_copy[base + i] : 8'h00);
      strike_column(8'h00);
    end
    if (column_forecast.size() > before_cnt) begin
      tail = column_forecast.pop_back();
      tail.last = 1'b1;
      column_forecast.push_back(tail);
    end
  endfunction

  task automatic report_mismatch(string field, int unsigned seen, int unsigned wanted);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, field, seen, wanted);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        strike_char(in_data);
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (char_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= char_stream.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    dmph_pkg::out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (column_forecast.size() == 0) begin
          report_mismatch("word with nothing expected", out_data.dots, 0);
        end else begin
          want = column_forecast.pop_front();
          if (out_data.kind !== want.kind)
            report_mismatch("kind", out_data.kind, want.kind);
          if (out_data.column_x !== want.column_x)
            report_mismatch("column_x", out_data.column_x, want.column_x);
          if (out_data.row_y !== want.row_y)
            report_mismatch("row_y", out_data.row_y, want.row_y);
          if (out_data.dots !== want.dots)
            report_mismatch("dots", out_data.dots, want.dots);
          if (out_data.underline_dot !== want.underline_dot)
            report_mismatch("underline_dot", out_data.underline_dot, want.underline_dot);
          if (out_data.last !== want.last)
            report_mismatch("last", out_data.last, want.last);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL dot_matrix_print_head");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic dmph_pkg::in_t load_word(int idx, int data);
    dmph_pkg::in_t word;
    word.command    = CMD_LOAD;
    word.char_code  = 8'($urandom());
    word.font_index = 9'(idx);
    word.font_data  = 8'(data);
    return word;
  endfunction

  function automatic dmph_pkg::in_t print_word(int code);
    dmph_pkg::in_t word;
    word.command    = CMD_PRINT;
    word.char_code  = 8'(code);
    word.font_index = 9'($urandom());
    word.font_data  = 8'($urandom());
    return word;
  endfunction

  task automatic send(dmph_pkg::in_t word);
    char_stream.push_back(word);
    words_queued++;
  endtask

  task automatic wait_drained();
    while (words_taken != words_queued || column_forecast.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [dmph_pkg::CFG_ADDR_W-1:0] idx, int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= dmph_pkg::CFG_DATA_W'(value);
    case (idx)
      dmph_pkg::CFG_PAGE_WIDTH:  pg_width = dmph_pkg::COORD_BITS'(value);
      dmph_pkg::CFG_PAGE_HEIGHT: pg_height = dmph_pkg::COORD_BITS'(value);
      dmph_pkg::CFG_UNDERLINE:   ul_on = value[0];
      dmph_pkg::CFG_GRAPHICS:    gfx_on = value[0];
      dmph_pkg::CFG_UNIX:        unix_on = value[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(int width, int height, int ul, int gfx, int unx);
    write_reg(dmph_pkg::CFG_PAGE_WIDTH, width);
    write_reg(dmph_pkg::CFG_PAGE_HEIGHT, height);
    write_reg(dmph_pkg::CFG_UNDERLINE, ul);
    write_reg(dmph_pkg::CFG_GRAPHICS, gfx);
    write_reg(dmph_pkg::CFG_UNIX, unx);
  endtask

  task automatic queue_random_text(int count);
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 50)      send(print_word($urandom_range(LOADED_LAST, dmph_pkg::CHAR_FIRST)));
      else if (pick < 55) send(print_word(dmph_pkg::CHAR_LAST));
      else if (pick < 63) send(print_word($urandom_range(255, 128)));
      else if (pick < 71) send(print_word(dmph_pkg::CHAR_LF));
      else if (pick < 77) send(print_word(dmph_pkg::CHAR_CR));
      else if (pick < 82) send(print_word($urandom_range(31, 0)));
      else                send(load_word($urandom_range(511, 0), $urandom_range(255, 0)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // load the fonts of every printable code that the streams use
    for (int i = 0; i < LOADED_ENTRIES; i++) send(load_word(i, $urandom_range(255, 0)));
    for (int i = 0; i < dmph_pkg::COLS_PER_CHAR; i++)
      send(load_word(LAST_CHAR_BASE + i, $urandom_range(255, 0)));
    send(print_word(40));
    send(print_word(dmph_pkg::CHAR_LF));
    send(print_word(200));
    wait_drained();

    apply_settings(12, 30, 1, 0, 0);
    send(load_word(0, 8'h00));
    send(load_word(dmph_pkg::STORE_SIZE - 1, 8'hFF));
    send(load_word(dmph_pkg::STORE_SIZE, 8'hA5));
    send(load_word(511, 8'h5A));
    send(print_word(dmph_pkg::CHAR_FIRST));
    send(print_word(dmph_pkg::CHAR_LAST));
    send(print_word(128));
    send(print_word(255));
    send(print_word(0));
    send(print_word(31));
    send(print_word(dmph_pkg::CHAR_CR));
    send(print_word(dmph_pkg::CHAR_LF));
    send(print_word(dmph_pkg::CHAR_LF));
    send(print_word(dmph_pkg::CHAR_LF));
    send(print_word(33));
    send(print_word(33));
    send(print_word(33));
    send(print_word(LOADED_LAST));
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: apply_settings(1, 10, 1, 0, 0);
        1: apply_settings(4095, 4095, 1, 1, 1);
        default: begin
          if (ph == 2) write_reg(CFG_SPARE, $urandom_range(4095, 0));
          apply_settings($urandom_range(40, 1), $urandom_range(120, 10),
                         $urandom_range(1, 0), $urandom_range(1, 0), $urandom_range(1, 0));
        end
      endcase
      @(posedge clk);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      queue_random_text(PHASE_WORDS);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("PASS dot_matrix_print_head");
    end else begin
      $display("FAIL dot_matrix_print_head");
    end
    $finish;
  end

endmodule

/* dot_matrix_print_head.f */
design/dmph_pkg.sv
design/dmph_front.sv
design/dmph_queue.sv
design/dmph_back.sv
design/dot_matrix_print_head.sv
bench/tb_dot_matrix_print_head.sv
